>>> hw/rtl/cbtm_pkg.sv
// shared types and constants for the color balance tone map
// no dependencies; used by cbtm_band, cbtm_stage and color_balance_tone_map
`default_nettype none

package cbtm_pkg;

    // pixel and register widths
    localparam int PIX_W     = 8;
    localparam int AMT_W     = 8;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    // default fraction bits of the curve constants
    localparam int CURVE_FRAC_BITS_DEF = 15;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RED_AMOUNTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_AMOUNTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_AMOUNTS  = 2'd2;

    // tonal band of one balance step
    typedef enum logic [1:0] {
        BAND_SHADOW = 2'd0,
        BAND_MID    = 2'd1,
        BAND_HIGH   = 2'd2
    } band_t;

    // one rgb pixel, red in the lowest bits
    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pix_t;

    // one signed amount per channel for a single band
    typedef struct packed {
        logic signed [AMT_W-1:0] blue;
        logic signed [AMT_W-1:0] green;
        logic signed [AMT_W-1:0] red;
    } amt_t;

endpackage

`default_nettype wire

>>> hw/rtl/cbtm_band.sv
// one balance step for one channel: curve lookup, multiply-add, clamp
// depends on cbtm_pkg
`default_nettype none

module cbtm_band #(
    parameter int             FRAC = cbtm_pkg::CURVE_FRAC_BITS_DEF,
    parameter cbtm_pkg::band_t BAND = cbtm_pkg::BAND_SHADOW
) (
    input  wire logic        [cbtm_pkg::PIX_W-1:0] v,
    input  wire logic signed [cbtm_pkg::AMT_W-1:0] amount,
    output logic             [cbtm_pkg::PIX_W-1:0] result
);

    localparam int PW = cbtm_pkg::PIX_W;
    localparam int AW = cbtm_pkg::AMT_W;
    // curve values are signed, at most a little above one
    localparam int CW = FRAC + 2;
    // running sum: value in the integer part plus the signed product
    localparam int SW = FRAC + PW + 3;
    localparam int DEPTH = 1 << PW;

    logic signed [CW-1:0] curve [DEPTH];
    logic        [PW-1:0] idx;
    logic signed [CW-1:0] w;
    logic signed [SW-1:0] v_ext;
    logic signed [SW-1:0] a_ext;
    logic signed [SW-1:0] w_ext;
    logic signed [SW-1:0] sum;

    generate
        if (BAND == cbtm_pkg::BAND_MID) begin : g_mid
            // mid(i) = 0.667 * (1 - ((i - 127) / 127)^2), rounded half away from zero
            for (genvar i = 0; i < DEPTH; i++) begin : g_ent
                localparam longint MD   = longint'(i) - 127;
                localparam longint MNUM = 667 * (16129 - MD * MD);
                localparam longint MABS = (MNUM < 0) ? -MNUM : MNUM;
                localparam longint MQ   =
                    ((MABS * (longint'(1) << FRAC)) * 2 + 16129000) / (2 * 16129000);
                localparam longint MVAL = (MNUM < 0) ? -MQ : MQ;
                assign curve[i] = CW'(MVAL);
            end
            assign idx = v;
        end else begin : g_low
            // low(i) = 1.075 - 16 / (i + 16), rounded to nearest
            logic pos;
            for (genvar i = 0; i < DEPTH; i++) begin : g_ent
                localparam longint LN   = longint'(i) + 16;
                localparam longint LNUM = 1075 * LN - 16000;
                localparam longint LDEN = 1000 * LN;
                localparam longint LQ   =
                    ((LNUM * (longint'(1) << FRAC)) * 2 + LDEN) / (2 * LDEN);
                assign curve[i] = CW'(LQ);
            end
            // shadows take low(v) for a boost, highlights take low(255 - v); a cut or zero amount uses the other index
            assign pos = !amount[AW-1] && (|amount);
            if (BAND == cbtm_pkg::BAND_HIGH) begin : g_hi
                assign idx = pos ? ~v : v;
            end else begin : g_sh
                assign idx = pos ? v : ~v;
            end
        end
    endgenerate

    assign w = curve[idx];

    // multiply-add in fixed point
    always_comb
    begin
        v_ext = signed'({{(SW - PW - FRAC){1'b0}}, v, {FRAC{1'b0}}});
        a_ext = SW'(amount);
        w_ext = SW'(w);
        sum   = v_ext + a_ext * w_ext;
    end

    // floor and clamp to 0..255
    always_comb
    begin
        if (sum[SW-1])
            result = '0;
        else if (|sum[SW-2:FRAC+PW])
            result = '1;
        else
            result = sum[FRAC+PW-1:FRAC];
    end

endmodule

`default_nettype wire

>>> hw/rtl/cbtm_stage.sv
// one registered pipeline stage: a balance step on all three channels
// depends on cbtm_pkg and cbtm_band
`default_nettype none

module cbtm_stage #(
    parameter int             FRAC = cbtm_pkg::CURVE_FRAC_BITS_DEF,
    parameter cbtm_pkg::band_t BAND = cbtm_pkg::BAND_SHADOW
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire cbtm_pkg::pix_t in_pix,
    input  wire cbtm_pkg::amt_t amounts,
    output logic                out_valid,
    input  wire logic           out_ready,
    output cbtm_pkg::pix_t      out_pix
);

    cbtm_pkg::pix_t pix_next;
    cbtm_pkg::pix_t pix_reg;
    logic           valid_reg;

    // per channel step
    cbtm_band #(.FRAC(FRAC), .BAND(BAND)) u_red (
        .v      (in_pix.red),
        .amount (amounts.red),
        .result (pix_next.red)
    );

    cbtm_band #(.FRAC(FRAC), .BAND(BAND)) u_green (
        .v      (in_pix.green),
        .amount (amounts.green),
        .result (pix_next.green)
    );

    cbtm_band #(.FRAC(FRAC), .BAND(BAND)) u_blue (
        .v      (in_pix.blue),
        .amount (amounts.blue),
        .result (pix_next.blue)
    );

    // stage takes a transfer when empty or when its own result leaves
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            pix_reg <= pix_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/color_balance_tone_map.sv
// top level: amount registers and three balance stages (shadows, midtones, highlights)
// depends on cbtm_pkg, cbtm_stage and cbtm_band
//
// channel   direction  handshake            payload
// s_        in         s_tvalid / s_tready  s_tdata: red_in, green_in, blue_in
// m_        out        m_tvalid / m_tready  m_tdata: red_out, green_out, blue_out
// cfg_      in         cfg_we               cfg_index, cfg_data
//
// one pixel per clock sustained while m_tready stays high; one register per
// band step, each step holding one curve lookup and one multiply-add per channel.
// reset clears the amount registers to zero and empties the pipeline.
// a stalled m_tready holds the last stage; earlier stages keep filling bubbles,
// so s_tready drops only when every stage holds a pixel.
`default_nettype none

module color_balance_tone_map #(
    parameter int CURVE_FRAC_BITS = cbtm_pkg::CURVE_FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [3*cbtm_pkg::PIX_W-1:0]      s_tdata,
    // red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [3*cbtm_pkg::PIX_W-1:0]      m_tdata,
    // configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [cbtm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cbtm_pkg::CFG_W-1:0]        cfg_data
);

    localparam int AW = cbtm_pkg::AMT_W;

    logic [cbtm_pkg::CFG_W-1:0] red_amounts_reg;
    logic [cbtm_pkg::CFG_W-1:0] green_amounts_reg;
    logic [cbtm_pkg::CFG_W-1:0] blue_amounts_reg;

    cbtm_pkg::amt_t amt_sh;
    cbtm_pkg::amt_t amt_mid;
    cbtm_pkg::amt_t amt_hi;

    logic           sh_valid;
    logic           sh_ready;
    cbtm_pkg::pix_t sh_pix;
    logic           mid_valid;
    logic           mid_ready;
    cbtm_pkg::pix_t mid_pix;
    cbtm_pkg::pix_t out_pix;

    // amount register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_amounts_reg   <= '0;
            green_amounts_reg <= '0;
            blue_amounts_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cbtm_pkg::REG_RED_AMOUNTS:   red_amounts_reg   <= cfg_data;
                cbtm_pkg::REG_GREEN_AMOUNTS: green_amounts_reg <= cfg_data;
                cbtm_pkg::REG_BLUE_AMOUNTS:  blue_amounts_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // split amounts by band
    always_comb
    begin
        amt_sh.red    = red_amounts_reg[0*AW +: AW];
        amt_sh.green  = green_amounts_reg[0*AW +: AW];
        amt_sh.blue   = blue_amounts_reg[0*AW +: AW];
        amt_mid.red   = red_amounts_reg[1*AW +: AW];
        amt_mid.green = green_amounts_reg[1*AW +: AW];
        amt_mid.blue  = blue_amounts_reg[1*AW +: AW];
        amt_hi.red    = red_amounts_reg[2*AW +: AW];
        amt_hi.green  = green_amounts_reg[2*AW +: AW];
        amt_hi.blue   = blue_amounts_reg[2*AW +: AW];
    end

    // shadows
    cbtm_stage #(.FRAC(CURVE_FRAC_BITS), .BAND(cbtm_pkg::BAND_SHADOW)) u_shadow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (cbtm_pkg::pix_t'(s_tdata)),
        .amounts   (amt_sh),
        .out_valid (sh_valid),
        .out_ready (sh_ready),
        .out_pix   (sh_pix)
    );

    // midtones
    cbtm_stage #(.FRAC(CURVE_FRAC_BITS), .BAND(cbtm_pkg::BAND_MID)) u_midtone (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sh_valid),
        .in_ready  (sh_ready),
        .in_pix    (sh_pix),
        .amounts   (amt_mid),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_pix   (mid_pix)
    );

    // highlights, last register drives the output transfer
    cbtm_stage #(.FRAC(CURVE_FRAC_BITS), .BAND(cbtm_pkg::BAND_HIGH)) u_highlight (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_pix    (mid_pix),
        .amounts   (amt_hi),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (out_pix)
    );

    assign m_tdata = out_pix;

endmodule

`default_nettype wire
